// ===== rtl/modbus_rtu_master_register_access_assert.svh =====
// assertion macros shared by the modbus master rtl
`ifndef MODBUS_RTU_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define MODBUS_RTU_MASTER_REGISTER_ACCESS_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mra_pkg.sv =====
// shared types, constants and crc function of the modbus master
package mra_pkg;

  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'd3;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

  // input opcodes
  localparam logic [2:0] OP_READ_ONE    = 3'd0;
  localparam logic [2:0] OP_WRITE       = 3'd1;
  localparam logic [2:0] OP_READ_WEIGHT = 3'd2;
  localparam logic [2:0] OP_RX_BYTE     = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  // completion status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TIMEOUT     = 3'd1;
  localparam logic [2:0] ST_MISMATCH    = 3'd2;
  localparam logic [2:0] ST_CRC_ERROR   = 3'd3;
  localparam logic [2:0] ST_COUNT_ERROR = 3'd4;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd5;

  localparam logic [7:0]  FN_READ          = 8'h03;
  localparam logic [7:0]  FN_WRITE         = 8'h06;
  localparam logic [7:0]  WEIGHT_BYTE_CNT  = 8'h04;
  localparam logic [15:0] READ_ONE_COUNT   = 16'h0001;
  localparam logic [15:0] READ_WEIGHT_CNT  = 16'h0002;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  // work handed from front to back: a request frame or a completion word
  typedef struct packed {
    logic        is_req;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] word;
    logic [2:0]  status;
    logic [31:0] data;
  } job_t;

  // one byte of crc-16, reflected polynomial, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mra_in_if.sv =====
// input word channel of the modbus master
interface mra_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] register_address;
  logic [15:0] write_value;
  logic [7:0]  channel_number;
  logic [7:0]  received_byte;

  modport source (output valid, output opcode, output register_address,
                  output write_value, output channel_number, output received_byte,
                  input ready);
  modport sink (input valid, input opcode, input register_address,
                input write_value, input channel_number, input received_byte,
                output ready);
endinterface

// ===== rtl/mra_out_if.sv =====
// result word channel of the modbus master
interface mra_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         transmit_byte;
  logic               last_of_frame;
  logic [2:0]         status;
  logic signed [31:0] read_data;

  modport source (output valid, output result_kind, output transmit_byte,
                  output last_of_frame, output status, output read_data,
                  input ready);
  modport sink (input valid, input result_kind, input transmit_byte,
                input last_of_frame, input status, input read_data,
                output ready);
endinterface

// ===== rtl/mra_front.sv =====
// front part: takes input words, tracks the transaction, queues jobs
module mra_front #(
  parameter int CHANNEL_COUNT = mra_pkg::CHANNEL_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  mra_in_if.sink          in_ch,
  input  logic [7:0]      slave_address,
  input  logic [15:0]     timeout_ticks,
  input  logic            q_full,
  output logic            q_push,
  output mra_pkg::job_t   q_job
);

  typedef enum logic [1:0] {
    KIND_READ_ONE = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_WEIGHT   = 2'd2
  } kind_t;

  logic        busy_r, busy_nxt;
  kind_t       kind_r, kind_nxt;
  logic [3:0]  byte_idx_r, byte_idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  reply_r [9];
  logic        rb_we;

  logic        in_fire;
  logic [3:0]  reply_len;
  logic [15:0] ticks_inc;
  logic        chan_ok;
  logic [7:0]  chan_m1;
  logic [7:0]  crc_lo_rx;
  logic [2:0]  done_status;
  logic [31:0] done_data;

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign reply_len = (kind_r == KIND_WEIGHT) ? 4'd9 :
                     (kind_r == KIND_WRITE)  ? 4'd8 : 4'd7;
  assign ticks_inc = (ticks_r == mra_pkg::TICKS_MAX) ? ticks_r : ticks_r + 16'd1;
  assign chan_ok   = (in_ch.channel_number != 8'd0) &&
                     (in_ch.channel_number <= 8'(CHANNEL_COUNT));
  assign chan_m1   = in_ch.channel_number - 8'd1;
  assign crc_lo_rx = (kind_r == KIND_WEIGHT) ? reply_r[7] : reply_r[5];

  // reply check on the last byte, which is still on the input
  always_comb begin
    done_status = mra_pkg::ST_OK;
    done_data   = 32'd0;
    if (kind_r != KIND_WRITE) begin
      if (reply_r[0] != slave_address || reply_r[1] != mra_pkg::FN_READ) begin
        done_status = mra_pkg::ST_MISMATCH;
      end else if (crc_lo_rx != crc_r[7:0] || in_ch.received_byte != crc_r[15:8]) begin
        done_status = mra_pkg::ST_CRC_ERROR;
      end else if (kind_r == KIND_WEIGHT) begin
        if (reply_r[2] != mra_pkg::WEIGHT_BYTE_CNT) begin
          done_status = mra_pkg::ST_COUNT_ERROR;
        end else begin
          done_data = {reply_r[3], reply_r[4], reply_r[5], reply_r[6]};
        end
      end else begin
        done_data = {16'd0, reply_r[3], reply_r[4]};
      end
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    kind_nxt     = kind_r;
    byte_idx_nxt = byte_idx_r;
    crc_nxt      = crc_r;
    ticks_nxt    = ticks_r;
    rb_we        = 1'b0;
    q_push       = 1'b0;
    q_job        = '0;
    q_job.slave  = slave_address;
    if (in_fire) begin
      case (in_ch.opcode)
        mra_pkg::OP_READ_ONE, mra_pkg::OP_WRITE, mra_pkg::OP_READ_WEIGHT: begin
          if (!busy_r) begin
            q_push = 1'b1;
            if (in_ch.opcode == mra_pkg::OP_READ_WEIGHT && !chan_ok) begin
              q_job.status = mra_pkg::ST_BAD_CHANNEL;
            end else begin
              q_job.is_req = 1'b1;
              busy_nxt     = 1'b1;
              byte_idx_nxt = 4'd0;
              crc_nxt      = mra_pkg::CRC_INIT;
              ticks_nxt    = 16'd0;
              if (in_ch.opcode == mra_pkg::OP_READ_ONE) begin
                kind_nxt   = KIND_READ_ONE;
                q_job.func = mra_pkg::FN_READ;
                q_job.addr = in_ch.register_address;
                q_job.word = mra_pkg::READ_ONE_COUNT;
              end else if (in_ch.opcode == mra_pkg::OP_WRITE) begin
                kind_nxt   = KIND_WRITE;
                q_job.func = mra_pkg::FN_WRITE;
                q_job.addr = in_ch.register_address;
                q_job.word = in_ch.write_value;
              end else begin
                kind_nxt   = KIND_WEIGHT;
                q_job.func = mra_pkg::FN_READ;
                q_job.addr = {7'd0, chan_m1, 1'b0};
                q_job.word = mra_pkg::READ_WEIGHT_CNT;
              end
            end
          end
        end
        mra_pkg::OP_RX_BYTE: begin
          if (busy_r) begin
            rb_we = 1'b1;
            if (byte_idx_r < reply_len - 4'd2) begin
              crc_nxt = mra_pkg::crc_byte(crc_r, in_ch.received_byte);
            end
            if (byte_idx_r == reply_len - 4'd1) begin
              q_push       = 1'b1;
              q_job.status = done_status;
              q_job.data   = done_data;
              busy_nxt     = 1'b0;
              byte_idx_nxt = 4'd0;
            end else begin
              byte_idx_nxt = byte_idx_r + 4'd1;
            end
          end
        end
        mra_pkg::OP_TICK: begin
          if (busy_r) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= timeout_ticks) begin
              q_push       = 1'b1;
              q_job.status = mra_pkg::ST_TIMEOUT;
              busy_nxt     = 1'b0;
              byte_idx_nxt = 4'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      kind_r     <= KIND_READ_ONE;
      byte_idx_r <= 4'd0;
      crc_r      <= mra_pkg::CRC_INIT;
      ticks_r    <= 16'd0;
    end else begin
      busy_r     <= busy_nxt;
      kind_r     <= kind_nxt;
      byte_idx_r <= byte_idx_nxt;
      crc_r      <= crc_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  // reply bytes, no reset
  always_ff @(posedge clk) begin
    if (rb_we) begin
      reply_r[byte_idx_r] <= in_ch.received_byte;
    end
  end

  `include "modbus_rtu_master_register_access_assert.svh"

  `MRA_ASSERT_NOW(a_idx_range, busy_r, byte_idx_r <= 4'd8, "reply index past frame")
  `MRA_ASSERT_NEXT(a_req_busy, q_push && q_job.is_req, busy_r, "request without busy")

endmodule

// ===== rtl/mra_fifo.sv =====
// short job queue between front and back
module mra_fifo #(
  parameter int DEPTH = mra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mra_pkg::job_t push_job,
  input  logic          pop,
  output mra_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mra_pkg::job_t     mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `include "modbus_rtu_master_register_access_assert.svh"

  `MRA_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
  `MRA_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ===== rtl/mra_back.sv =====
// back part: serializes request frames with crc, emits completion words
module mra_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mra_pkg::job_t head_job,
  input  logic          q_empty,
  output logic          q_pop,
  mra_out_if.source     out_ch
);

  localparam logic [2:0] STEP_FIRST  = 3'd1;
  localparam logic [2:0] STEP_CRC_LO = 3'd6;
  localparam logic [2:0] STEP_CRC_HI = 3'd7;

  logic          active_r, active_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [15:0]   crc_r, crc_nxt;
  mra_pkg::job_t job_r, job_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          kind_r, kind_nxt;
  logic [7:0]    tx_r, tx_nxt;
  logic          last_r, last_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [31:0]   data_r, data_nxt;

  logic          adv;
  logic [7:0]    frame_byte;

  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    case (step_r)
      3'd1:        frame_byte = job_r.func;
      3'd2:        frame_byte = job_r.addr[15:8];
      3'd3:        frame_byte = job_r.addr[7:0];
      3'd4:        frame_byte = job_r.word[15:8];
      3'd5:        frame_byte = job_r.word[7:0];
      STEP_CRC_LO: frame_byte = crc_r[7:0];
      STEP_CRC_HI: frame_byte = crc_r[15:8];
      default:     frame_byte = job_r.slave;
    endcase
  end

  always_comb begin
    active_nxt    = active_r;
    step_nxt      = step_r;
    crc_nxt       = crc_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    tx_nxt        = tx_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    q_pop         = 1'b0;
    if (adv) begin
      if (active_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = 1'b0;
        tx_nxt        = frame_byte;
        last_nxt      = (step_r == STEP_CRC_HI);
        status_nxt    = mra_pkg::ST_OK;
        data_nxt      = 32'd0;
        if (step_r < STEP_CRC_LO) begin
          crc_nxt = mra_pkg::crc_byte(crc_r, frame_byte);
        end
        if (step_r == STEP_CRC_HI) begin
          active_nxt = 1'b0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        if (head_job.is_req) begin
          kind_nxt   = 1'b0;
          tx_nxt     = head_job.slave;
          last_nxt   = 1'b0;
          status_nxt = mra_pkg::ST_OK;
          data_nxt   = 32'd0;
          job_nxt    = head_job;
          crc_nxt    = mra_pkg::crc_byte(mra_pkg::CRC_INIT, head_job.slave);
          step_nxt   = STEP_FIRST;
          active_nxt = 1'b1;
        end else begin
          kind_nxt   = 1'b1;
          tx_nxt     = 8'd0;
          last_nxt   = 1'b1;
          status_nxt = head_job.status;
          data_nxt   = head_job.data;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r    <= crc_nxt;
    job_r    <= job_nxt;
    kind_r   <= kind_nxt;
    tx_r     <= tx_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.transmit_byte = tx_r;
  assign out_ch.last_of_frame = last_r;
  assign out_ch.status        = status_r;
  assign out_ch.read_data     = $signed(data_r);

  `include "modbus_rtu_master_register_access_assert.svh"

  `MRA_ASSERT_NOW(a_active_valid, active_r, out_valid_r, "frame in progress without word")

endmodule

// ===== rtl/modbus_rtu_master_register_access.sv =====
// top level of the modbus rtu master: config registers, front, queue, back
//
// usage
// - in_ch carries one word per command, reply byte or timer tick; opcode selects
//   read one register, write register, read weight, received byte or tick
// - out_ch carries the request frame bytes (result_kind 0, last_of_frame on the
//   eighth byte, crc low byte first) and one completion word per transaction
//   (result_kind 1) with status and read_data
// - cfg_we / cfg_index / cfg_wdata write slave_address (index 0) and
//   timeout_ticks (index 1); write them only while no transaction is pending
// - a taken input word goes into the job queue, then the back end loads its
//   first result word into the output register; a request frame streams at
//   one byte per cycle while out_ch.ready is high
// - throughput: one input word per cycle while the job queue has room; the
//   back end (8 bytes per frame, 1 word per completion) sets the sustained rate
// - a stalled receiver holds the output register; the queue keeps taking
//   jobs until it is full, then in_ch.ready drops
// - reset (rst_n low, synchronous) idles the block, empties the queue and
//   loads slave_address 3 and timeout_ticks 500
module modbus_rtu_master_register_access #(
  parameter int CHANNEL_COUNT = mra_pkg::CHANNEL_COUNT_DEF,
  parameter int QUEUE_DEPTH   = mra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  mra_in_if.sink      in_ch,
  mra_out_if.source   out_ch
);

  // configuration registers
  logic [7:0]  slave_addr_r;
  logic [15:0] timeout_r;

  // front to queue to back
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  mra_pkg::job_t q_in_job;
  mra_pkg::job_t q_head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mra_pkg::SLAVE_ADDRESS_RST;
      timeout_r    <= mra_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mra_pkg::CFG_SLAVE_ADDRESS: slave_addr_r <= cfg_wdata[7:0];
        mra_pkg::CFG_TIMEOUT_TICKS: timeout_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // front: command decode, reply collection with running crc, timeout count
  mra_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .slave_address (slave_addr_r),
    .timeout_ticks (timeout_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_in_job)
  );

  // decoupling queue so the front keeps taking words while frames stream out
  mra_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: frame serializer with request crc, output register
  mra_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (q_head_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== test/mra_checker.sv =====
// scoreboard for the modbus master: predicts every result word and compares it
`timescale 1ns / 100ps
module mra_checker
  import mra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  mra_in_if           in_mon,
  mra_out_if          out_mon,
  output int          mismatch_count,
  output int          pending_count
);

  typedef enum logic [1:0] {TXN_READ_ONE, TXN_WRITE, TXN_WEIGHT} txn_kind_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  transmit_byte;
    logic        last_of_frame;
    logic [2:0]  status;
    logic [31:0] read_data;
  } result_word_t;

  result_word_t expected_words[$];

  logic [7:0]  slave_addr;
  logic [15:0] timeout_limit;
  logic        busy;
  txn_kind_t   txn_kind;
  int          reply_idx;
  logic [7:0]  reply_buf[9];
  logic [15:0] reply_crc;
  logic [15:0] tick_count;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = {1'b0, c[15:1]} ^ CRC_POLY;
      else c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  function automatic string describe(input result_word_t w);
    return $sformatf("kind %0d byte %02h last %0d status %0d data %08h",
                     w.result_kind, w.transmit_byte, w.last_of_frame, w.status, w.read_data);
  endfunction

  function automatic void reset_model();
    slave_addr    = SLAVE_ADDRESS_RST;
    timeout_limit = TIMEOUT_TICKS_RST;
    busy          = 1'b0;
    txn_kind      = TXN_READ_ONE;
    reply_idx     = 0;
    reply_crc     = CRC_INIT;
    tick_count    = '0;
    expected_words.delete();
  endfunction

  function automatic void add_completion(input logic [2:0] st, input logic [31:0] data);
    expected_words.push_back({1'b1, 8'h00, 1'b1, st, data});
  endfunction

  // eight request bytes, crc low byte first, then wait for the reply
  function automatic void issue_request(input logic [7:0] fn, input logic [15:0] addr,
                                        input logic [15:0] word, input txn_kind_t kind);
    logic [7:0]  frame[8];
    logic [15:0] crc;
    frame[0] = slave_addr;
    frame[1] = fn;
    frame[2] = addr[15:8];
    frame[3] = addr[7:0];
    frame[4] = word[15:8];
    frame[5] = word[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      expected_words.push_back({1'b0, frame[i], i == 7, ST_OK, 32'd0});
    end
    busy       = 1'b1;
    txn_kind   = kind;
    reply_idx  = 0;
    reply_crc  = CRC_INIT;
    tick_count = '0;
  endfunction

  function automatic logic [2:0] close_reply(output logic [31:0] data);
    int len;
    len  = (txn_kind == TXN_WEIGHT) ? 9 : 7;
    data = '0;
    if (txn_kind == TXN_WRITE) return ST_OK;
    if (reply_buf[0] != slave_addr || reply_buf[1] != FN_READ) return ST_MISMATCH;
    if (reply_buf[len-2] != reply_crc[7:0] || reply_buf[len-1] != reply_crc[15:8])
      return ST_CRC_ERROR;
    if (txn_kind == TXN_WEIGHT) begin
      if (reply_buf[2] != WEIGHT_BYTE_CNT) return ST_COUNT_ERROR;
      data = {reply_buf[3], reply_buf[4], reply_buf[5], reply_buf[6]};
    end else begin
      data = {16'h0000, reply_buf[3], reply_buf[4]};
    end
    return ST_OK;
  endfunction

  function automatic void take_reply_byte(input logic [7:0] b);
    int          len;
    logic [2:0]  st;
    logic [31:0] data;
    len = (txn_kind == TXN_WEIGHT) ? 9 : (txn_kind == TXN_WRITE) ? 8 : 7;
    reply_buf[reply_idx] = b;
    // crc covers everything but the two crc bytes
    if (reply_idx + 2 < len) reply_crc = crc16_step(reply_crc, b);
    reply_idx++;
    if (reply_idx >= len) begin
      st        = close_reply(data);
      busy      = 1'b0;
      reply_idx = 0;
      add_completion(st, data);
    end
  endfunction

  function automatic void take_input();
    case (in_mon.opcode)
      OP_READ_ONE: begin
        if (!busy) issue_request(FN_READ, in_mon.register_address, READ_ONE_COUNT, TXN_READ_ONE);
      end
      OP_WRITE: begin
        if (!busy) issue_request(FN_WRITE, in_mon.register_address, in_mon.write_value, TXN_WRITE);
      end
      OP_READ_WEIGHT: begin
        if (!busy) begin
          if (in_mon.channel_number < 1 || in_mon.channel_number > CHANNEL_COUNT_DEF)
            add_completion(ST_BAD_CHANNEL, 32'd0);
          else
            issue_request(FN_READ, {7'd0, in_mon.channel_number - 8'd1, 1'b0},
                          READ_WEIGHT_CNT, TXN_WEIGHT);
        end
      end
      OP_RX_BYTE: begin
        if (busy) take_reply_byte(in_mon.received_byte);
      end
      OP_TICK: begin
        if (busy) begin
          if (tick_count != TICKS_MAX) tick_count++;
          if (tick_count >= timeout_limit) begin
            busy      = 1'b0;
            reply_idx = 0;
            add_completion(ST_TIMEOUT, 32'd0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    result_word_t seen;
    result_word_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      // results first: a word taken this cycle cannot answer an input of this cycle
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.result_kind, out_mon.transmit_byte, out_mon.last_of_frame,
                out_mon.status, out_mon.read_data};
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result word: %s", describe(seen));
        end else begin
          want = expected_words.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %s, got %s", describe(want), describe(seen));
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SLAVE_ADDRESS) slave_addr = cfg_wdata[7:0];
        else timeout_limit = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) take_input();
    end
    pending_count <= expected_words.size();
  end

endmodule

// ===== test/tb_modbus_rtu_master_register_access.sv =====
// testbench top for the modbus master: clock, reset, stimulus and the verdict
`timescale 1ns / 100ps
module tb_modbus_rtu_master_register_access;
  import mra_pkg::*;

  // generous bound, far above the slowest correct run
  localparam int CYCLE_LIMIT = 400000;

  // opcodes the block leaves alone
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // byte count field of a read-one reply (not checked by the master)
  localparam logic [7:0] READ_ONE_BYTE_CNT = 8'd2;

  // how the slave answers a request
  typedef enum int {
    RPL_GOOD, RPL_BAD_ID, RPL_BAD_FN, RPL_BAD_CRC, RPL_BAD_COUNT, RPL_TIMEOUT
  } reply_shape_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  mra_in_if  in_ch ();
  mra_out_if out_ch ();

  int mismatches;
  int pending;

  // idle percentages of sender and receiver, share of stray words in a reply
  int tx_idle_pct;
  int rx_idle_pct;
  int stray_pct;
  int words_sent;
  int cycle_count;

  // what the slave side believes the block is configured with
  logic [7:0]  cur_slave;
  logic [15:0] cur_timeout;

  modbus_rtu_master_register_access dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mra_checker link_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver side: ready dropped at random, per the current idle share
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // crc-16 of a slave reply, used to build well-formed answers
  function automatic logic [15:0] frame_crc(input logic [7:0] bytes[9], input int count);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < count; i++) begin
      c ^= {8'h00, bytes[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // one word on the input channel; called in the step of a rising edge and
  // returns in the step of the edge that took the word, valid still high
  task automatic push_word(input logic [2:0] op, input logic [15:0] addr,
                           input logic [15:0] value, input logic [7:0] chan,
                           input logic [7:0] rx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= op;
    in_ch.register_address <= addr;
    in_ch.write_value      <= value;
    in_ch.channel_number   <= chan;
    in_ch.received_byte    <= rx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // a word that lands in the middle of a reply: tick, spare opcode, or a
  // command the busy block must drop (only when no timeout can intervene)
  task automatic stray_word();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0)
      push_word(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    else if (pick == 1 || cur_timeout <= 32)
      push_word(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 16'($urandom), 16'($urandom),
                8'($urandom), 8'($urandom));
    else
      push_word(3'($urandom_range(OP_READ_WEIGHT, OP_READ_ONE)), 16'($urandom),
                16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a command followed by the slave's answer in the given shape
  task automatic run_transaction(input logic [2:0] op, input logic [15:0] addr,
                                 input logic [15:0] value, input logic [7:0] chan,
                                 input logic [31:0] payload, input reply_shape_t shape);
    logic [7:0]  reply[9];
    logic [15:0] crc;
    int          len;
    int          cut;
    // a timeout needs timeout_ticks ticks, only affordable for short limits
    if (shape == RPL_TIMEOUT && cur_timeout > 64) shape = RPL_GOOD;
    len = (op == OP_READ_WEIGHT) ? 9 : (op == OP_WRITE) ? 8 : 7;
    push_word(op, addr, value, chan, 8'($urandom));

    foreach (reply[i]) reply[i] = 8'($urandom);
    reply[0] = cur_slave;
    if (op == OP_WRITE) begin
      // echo of the request
      reply[1] = FN_WRITE;
      {reply[2], reply[3]} = addr;
      {reply[4], reply[5]} = value;
    end else if (op == OP_READ_WEIGHT) begin
      reply[1] = FN_READ;
      reply[2] = WEIGHT_BYTE_CNT;
      {reply[3], reply[4], reply[5], reply[6]} = payload;
    end else begin
      reply[1] = FN_READ;
      reply[2] = READ_ONE_BYTE_CNT;
      {reply[3], reply[4]} = payload[15:0];
    end

    // corruptions go in before the crc so only the intended check trips
    case (shape)
      RPL_BAD_ID:    reply[0] = cur_slave ^ 8'($urandom_range(255, 1));
      RPL_BAD_FN:    reply[1] = reply[1] ^ 8'($urandom_range(255, 1));
      RPL_BAD_COUNT: reply[2] = reply[2] ^ 8'($urandom_range(255, 1));
      default: ;
    endcase
    crc = frame_crc(reply, len - 2);
    reply[len-2] = crc[7:0];
    reply[len-1] = crc[15:8];
    if (shape == RPL_BAD_CRC) reply[len - 1 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));

    // a timed-out reply stops short, then the timer runs out
    cut = (shape == RPL_TIMEOUT) ? $urandom_range(len - 1, 0) : len;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < stray_pct) stray_word();
      push_word(OP_RX_BYTE, 16'($urandom), 16'($urandom), 8'($urandom), reply[i]);
    end
    if (shape == RPL_TIMEOUT) repeat (cur_timeout) push_word(OP_TICK, 16'($urandom),
                                                            16'($urandom), 8'($urandom),
                                                            8'($urandom));
  endtask

  // enough random bytes to close any open transaction
  task automatic flush_reply();
    repeat (9) push_word(OP_RX_BYTE, 16'($urandom), 16'($urandom), 8'($urandom),
                         8'($urandom));
  endtask

  task automatic random_transaction();
    logic [2:0]   op;
    reply_shape_t shape;
    int           roll;
    op   = 3'($urandom_range(OP_READ_WEIGHT, OP_READ_ONE));
    roll = $urandom_range(99);
    if (roll < 60) shape = RPL_GOOD;
    else if (roll < 68) shape = RPL_BAD_ID;
    else if (roll < 76) shape = RPL_BAD_FN;
    else if (roll < 86) shape = RPL_BAD_CRC;
    else if (roll < 92) shape = RPL_BAD_COUNT;
    else shape = RPL_TIMEOUT;
    run_transaction(op, 16'($urandom), 16'($urandom), 8'($urandom_range(CHANNEL_COUNT_DEF, 1)),
                    $urandom, shape);
  endtask

  // mostly whole transactions, some bad channels, some raw noise
  task automatic random_phase(input int target);
    int roll;
    while (words_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        random_transaction();
      end else if (roll < 88) begin
        push_word(OP_READ_WEIGHT, 16'($urandom), 16'($urandom),
                  $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, CHANNEL_COUNT_DEF + 1)),
                  8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1))
          push_word(3'($urandom_range(OP_SPARE_HI, OP_READ_ONE)), 16'($urandom),
                    16'($urandom), 8'($urandom), 8'($urandom));
        flush_reply();
      end
    end
  endtask

  // close any transaction, then hold the sender off until every expected
  // word has come out and the front end has had time to go quiet
  task automatic settle();
    flush_reply();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // both registers, back to back, with the block idle
  task automatic reconfigure(input logic [7:0] slave, input logic [15:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_wdata <= {8'h00, slave};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_slave   = slave;
    cur_timeout = ticks;
  endtask

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.opcode           = OP_READ_ONE;
    in_ch.register_address = '0;
    in_ch.write_value      = '0;
    in_ch.channel_number   = '0;
    in_ch.received_byte    = '0;
    out_ch.ready           = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_SLAVE_ADDRESS;
    cfg_wdata              = '0;
    rst_n                  = 1'b0;
    tx_idle_pct            = 30;
    rx_idle_pct            = 65;
    stray_pct              = 5;
    words_sent             = 0;
    cur_slave              = SLAVE_ADDRESS_RST;
    cur_timeout            = TIMEOUT_TICKS_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, on the reset configuration
    // idle block: tick, byte and spare opcodes have no effect
    push_word(OP_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_word(OP_RX_BYTE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_word(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_word(OP_SPARE_LO, 16'h0000, 16'h0000, 8'h00, 8'h00);
    // address and data extremes on good replies
    run_transaction(OP_READ_ONE, 16'hFFFF, 16'h0000, 8'h00, 32'h0000_FFFF, RPL_GOOD);
    run_transaction(OP_READ_ONE, 16'h0000, 16'hFFFF, 8'hFF, 32'h0000_0000, RPL_GOOD);
    run_transaction(OP_WRITE, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0, RPL_GOOD);
    // write echo with a wrong id still completes ok
    run_transaction(OP_WRITE, 16'h0000, 16'h0000, 8'hFF, 32'h0, RPL_BAD_ID);
    // most negative and most positive weights, lowest and highest channel
    run_transaction(OP_READ_WEIGHT, 16'h0000, 16'h0000, 8'd1, 32'h8000_0000, RPL_GOOD);
    run_transaction(OP_READ_WEIGHT, 16'hFFFF, 16'hFFFF, 8'd4, 32'h7FFF_FFFF, RPL_GOOD);
    // each failing check of a reply
    run_transaction(OP_READ_WEIGHT, 16'h0000, 16'h0000, 8'd2, 32'hFFFF_FFFF, RPL_BAD_COUNT);
    run_transaction(OP_READ_WEIGHT, 16'h0000, 16'h0000, 8'd3, $urandom, RPL_BAD_CRC);
    run_transaction(OP_READ_WEIGHT, 16'h0000, 16'h0000, 8'd1, $urandom, RPL_BAD_FN);
    run_transaction(OP_READ_ONE, 16'($urandom), 16'h0000, 8'h00, $urandom, RPL_BAD_ID);
    run_transaction(OP_READ_ONE, 16'($urandom), 16'h0000, 8'h00, $urandom, RPL_BAD_FN);
    run_transaction(OP_READ_ONE, 16'($urandom), 16'h0000, 8'h00, $urandom, RPL_BAD_CRC);
    // channels outside 1..4 complete at once with bad channel
    push_word(OP_READ_WEIGHT, 16'h0000, 16'h0000, 8'd0, 8'h00);
    push_word(OP_READ_WEIGHT, 16'h0000, 16'h0000, 8'd5, 8'h00);
    push_word(OP_READ_WEIGHT, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    // commands, ticks and spare words thrown in while a reply is open
    stray_pct = 100;
    run_transaction(OP_READ_ONE, 16'($urandom), 16'h0000, 8'h00, $urandom, RPL_GOOD);
    stray_pct = 5;

    // short timeout, slave address at its low end
    settle();
    reconfigure(8'd1, 16'd3);
    run_transaction(OP_READ_ONE, 16'($urandom), 16'($urandom), 8'h00, $urandom, RPL_TIMEOUT);
    run_transaction(OP_WRITE, 16'($urandom), 16'($urandom), 8'h00, $urandom, RPL_TIMEOUT);
    run_transaction(OP_READ_WEIGHT, 16'($urandom), 16'($urandom), 8'd4, $urandom,
                    RPL_TIMEOUT);
    random_phase(220);

    // roles swapped: sender idles more than receiver; top slave address,
    // longest timeout
    settle();
    tx_idle_pct = 65;
    rx_idle_pct = 30;
    reconfigure(8'd247, 16'hFFFF);
    random_phase(310);

    // a single tick ends any transaction
    settle();
    reconfigure(8'($urandom_range(246, 2)), 16'd1);
    random_phase(380);

    // no idling at all, mid-range settings
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    reconfigure(8'($urandom_range(246, 2)), 16'($urandom_range(40, 5)));
    random_phase(470);

    // drain and let the block run dry before the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
